>>> rtl/mbqf_pkg.sv
// Shared types, constants and the per-form micro-program of the multichannel biquad filter.
// No dependencies; all other files use it through scoped names.
package mbqf_pkg;

    // Width constants
    localparam int SAMPLE_W = 24;
    localparam int CHAN_W   = 3;
    localparam int STATE_W  = 40;
    localparam int COEF_W   = 32;
    localparam int ACC_W    = 48;
    localparam int PC_W     = 5;
    localparam int CFG_IDX_W = 3;

    // Filter structure codes
    typedef enum logic [1:0] {
        FORM_DF1  = 2'd0,
        FORM_DF2  = 2'd1,
        FORM_TDF1 = 2'd2,
        FORM_TDF2 = 2'd3
    } t_form;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORM = 3'd0,
        CFG_B0   = 3'd1,
        CFG_B1   = 3'd2,
        CFG_B2   = 3'd3,
        CFG_A1   = 3'd4,
        CFG_A2   = 3'd5
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Micro-op kinds
    typedef enum logic [2:0] {
        U_INIT,   // acc <= operand
        U_ADD,    // acc <= acc + operand
        U_MUL,    // acc += round(operand * coef), two multiplier passes
        U_SAT,    // dest <= sat40(acc) once the unit has drained
        U_END
    } t_ukind;

    // Operand sources
    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_X,
        SRC_W,
        SRC_Y,
        SRC_IN1,
        SRC_IN2,
        SRC_OUT1,
        SRC_OUT2,
        SRC_INR1,
        SRC_INR2
    } t_src;

    // Coefficient select
    typedef enum logic [2:0] {
        C_B0,
        C_B1,
        C_B2,
        C_A1,
        C_A2
    } t_coef_sel;

    // Result destinations
    typedef enum logic [2:0] {
        DST_W,
        DST_Y,
        DST_T1,
        DST_T2,
        DST_T3,
        DST_T4
    } t_dst;

    typedef struct packed {
        t_ukind    kind;
        t_src      src;
        t_coef_sel coef;
        t_dst      dst;
    } t_uop;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic                      issue;    // start a multiplier pass
        logic                      hi;       // pass uses upper operand half
        logic                      init;
        logic                      add;
        logic signed [STATE_W-1:0] operand;
        logic signed [COEF_W-1:0]  coef;
    } t_mac_ctrl;

    // Status back from the multiply-accumulate unit
    typedef struct packed {
        logic                      busy;     // a product is still on its way to acc
        logic signed [STATE_W-1:0] acc_sat;
    } t_mac_stat;

    // One channel's delay state
    typedef struct packed {
        logic signed [STATE_W-1:0] in1;
        logic signed [STATE_W-1:0] in2;
        logic signed [STATE_W-1:0] out1;
        logic signed [STATE_W-1:0] out2;
        logic signed [STATE_W-1:0] inr1;
        logic signed [STATE_W-1:0] inr2;
    } t_row;

    localparam logic signed [ACC_W-1:0] S40_MAX = 48'sd549755813887;
    localparam logic signed [ACC_W-1:0] S40_MIN = -48'sd549755813888;

    // Clamp an accumulator value to the signed 40-bit range
    function automatic logic signed [STATE_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > S40_MAX) begin
            r = S40_MAX[STATE_W-1:0];
        end else if (v < S40_MIN) begin
            r = S40_MIN[STATE_W-1:0];
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    function automatic t_uop mk(input t_ukind k, input t_src s, input t_coef_sel c,
                                input t_dst d);
        t_uop u;
        u.kind = k;
        u.src  = s;
        u.coef = c;
        u.dst  = d;
        return u;
    endfunction

    // Micro-program: one sequence per filter structure
    function automatic t_uop ucode(input t_form form, input logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(U_END, SRC_ZERO, C_B0, DST_Y);
        unique case (form)
            FORM_DF1: begin
                unique case (pc)
                    5'd0: u = mk(U_INIT, SRC_ZERO, C_B0, DST_Y);
                    5'd1: u = mk(U_MUL,  SRC_X,    C_B0, DST_Y);
                    5'd2: u = mk(U_MUL,  SRC_IN1,  C_B1, DST_Y);
                    5'd3: u = mk(U_MUL,  SRC_IN2,  C_B2, DST_Y);
                    5'd4: u = mk(U_MUL,  SRC_OUT1, C_A1, DST_Y);
                    5'd5: u = mk(U_MUL,  SRC_OUT2, C_A2, DST_Y);
                    5'd6: u = mk(U_SAT,  SRC_ZERO, C_B0, DST_Y);
                    default: u = mk(U_END, SRC_ZERO, C_B0, DST_Y);
                endcase
            end
            FORM_DF2: begin
                unique case (pc)
                    5'd0: u = mk(U_INIT, SRC_X,    C_B0, DST_W);
                    5'd1: u = mk(U_MUL,  SRC_INR1, C_A1, DST_W);
                    5'd2: u = mk(U_MUL,  SRC_INR2, C_A2, DST_W);
                    5'd3: u = mk(U_SAT,  SRC_ZERO, C_B0, DST_W);
                    5'd4: u = mk(U_INIT, SRC_ZERO, C_B0, DST_Y);
                    5'd5: u = mk(U_MUL,  SRC_W,    C_B0, DST_Y);
                    5'd6: u = mk(U_MUL,  SRC_INR1, C_B1, DST_Y);
                    5'd7: u = mk(U_MUL,  SRC_INR2, C_B2, DST_Y);
                    5'd8: u = mk(U_SAT,  SRC_ZERO, C_B0, DST_Y);
                    default: u = mk(U_END, SRC_ZERO, C_B0, DST_Y);
                endcase
            end
            FORM_TDF1: begin
                unique case (pc)
                    5'd0:  u = mk(U_INIT, SRC_X,    C_B0, DST_W);
                    5'd1:  u = mk(U_ADD,  SRC_INR2, C_B0, DST_W);
                    5'd2:  u = mk(U_SAT,  SRC_ZERO, C_B0, DST_W);
                    5'd3:  u = mk(U_INIT, SRC_IN2,  C_B0, DST_Y);
                    5'd4:  u = mk(U_MUL,  SRC_W,    C_B0, DST_Y);
                    5'd5:  u = mk(U_SAT,  SRC_ZERO, C_B0, DST_Y);
                    5'd6:  u = mk(U_INIT, SRC_IN1,  C_B1, DST_T2);
                    5'd7:  u = mk(U_MUL,  SRC_W,    C_B1, DST_T2);
                    5'd8:  u = mk(U_SAT,  SRC_ZERO, C_B1, DST_T2);
                    5'd9:  u = mk(U_INIT, SRC_INR1, C_A1, DST_T1);
                    5'd10: u = mk(U_MUL,  SRC_W,    C_A1, DST_T1);
                    5'd11: u = mk(U_SAT,  SRC_ZERO, C_A1, DST_T1);
                    5'd12: u = mk(U_INIT, SRC_ZERO, C_B2, DST_T3);
                    5'd13: u = mk(U_MUL,  SRC_W,    C_B2, DST_T3);
                    5'd14: u = mk(U_SAT,  SRC_ZERO, C_B2, DST_T3);
                    5'd15: u = mk(U_INIT, SRC_ZERO, C_A2, DST_T4);
                    5'd16: u = mk(U_MUL,  SRC_W,    C_A2, DST_T4);
                    5'd17: u = mk(U_SAT,  SRC_ZERO, C_A2, DST_T4);
                    default: u = mk(U_END, SRC_ZERO, C_B0, DST_Y);
                endcase
            end
            FORM_TDF2: begin
                unique case (pc)
                    5'd0:  u = mk(U_INIT, SRC_IN2,  C_B0, DST_Y);
                    5'd1:  u = mk(U_MUL,  SRC_X,    C_B0, DST_Y);
                    5'd2:  u = mk(U_SAT,  SRC_ZERO, C_B0, DST_Y);
                    5'd3:  u = mk(U_INIT, SRC_IN1,  C_B1, DST_T2);
                    5'd4:  u = mk(U_MUL,  SRC_X,    C_B1, DST_T2);
                    5'd5:  u = mk(U_MUL,  SRC_Y,    C_A1, DST_T2);
                    5'd6:  u = mk(U_SAT,  SRC_ZERO, C_A1, DST_T2);
                    5'd7:  u = mk(U_INIT, SRC_ZERO, C_B2, DST_T1);
                    5'd8:  u = mk(U_MUL,  SRC_X,    C_B2, DST_T1);
                    5'd9:  u = mk(U_MUL,  SRC_Y,    C_A2, DST_T1);
                    5'd10: u = mk(U_SAT,  SRC_ZERO, C_A2, DST_T1);
                    default: u = mk(U_END, SRC_ZERO, C_B0, DST_Y);
                endcase
            end
            default: u = mk(U_END, SRC_ZERO, C_B0, DST_Y);
        endcase
        return u;
    endfunction

endpackage

>>> rtl/multichannel_biquad_filter.sv
// Top level: multichannel biquad filter, micro-sequencer, operand selection, registers.
// Depends on mbqf_pkg, mbqf_mac and mbqf_state.
//
// Usage:
//   Input stream (s_*): tuser carries the channel, tdata the Q1.23 sample.
//   Output stream (m_*): tdata carries the saturated Q1.23 result, tuser the channel.
//   Config channel (i_cfg_*): index 0 selects the structure (0 direct I, 1 direct II,
//   2 transposed I, 3 transposed II) and clears every channel's delay state;
//   indexes 1..5 load b0, b1, b2, a1, a2 (Q2.30, feedback terms are added).
//   Writes are taken at any time but belong between requests.
// Timing:
//   One request at a time; s_tready is high only when the sequencer is idle.
//   Each product costs two passes through the shared 21x32 multiplier, and each
//   saturated intermediate waits for the unit to drain. A channel beyond CHANNELS
//   skips the computation and returns a zero result.
//   A finished result waits in the sequencer while the output register is full;
//   once it is loaded, the sequencer returns to idle and takes the next request.
// Reset:
//   Structure transposed II, b0 = 1.0, other coefficients zero, all state zero.
module multichannel_biquad_filter #(
    parameter int CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [23:0] sample_in
    input  logic [2:0]  s_tuser,     // [2:0] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [23:0] sample_out
    output logic [2:0]  m_tuser,     // [2:0] channel_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers
    mbqf_pkg::t_form              r_form;
    logic signed [31:0]           r_b0, r_b1, r_b2, r_a1, r_a2;

    // Sequencer
    mbqf_pkg::t_state             r_state, n_state;
    logic [mbqf_pkg::PC_W-1:0]    r_pc, n_pc;
    logic                         r_half, n_half;

    // Working values
    logic signed [39:0]           r_x, r_w, r_y, r_t1, r_t2, r_t3, r_t4;
    logic signed [39:0]           n_w, n_y, n_t1, n_t2, n_t3, n_t4;
    logic [2:0]                   r_chan;
    logic                         r_inrange;

    // Output register
    logic                         r_m_tvalid, n_m_tvalid;
    logic [23:0]                  r_m_tdata, n_m_tdata;
    logic [2:0]                   r_m_tuser, n_m_tuser;

    mbqf_pkg::t_uop               uop;
    mbqf_pkg::t_mac_ctrl          mac_ctrl;
    mbqf_pkg::t_mac_stat          mac_stat;
    mbqf_pkg::t_row               row_old, row_new;
    logic signed [39:0]           opnd;
    logic signed [31:0]           coefv;
    logic                         accept, cfg_wr, form_wr, wr_en;
    logic signed [40:0]           y_rnd;
    logic signed [32:0]           y_q;
    logic [23:0]                  y_sample;

    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (r_state == mbqf_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign form_wr     = cfg_wr && (i_cfg_index == mbqf_pkg::CFG_FORM);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form <= mbqf_pkg::FORM_TDF2;
            r_b0   <= 32'sh4000_0000;
            r_b1   <= '0;
            r_b2   <= '0;
            r_a1   <= '0;
            r_a2   <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                mbqf_pkg::CFG_FORM: r_form <= mbqf_pkg::t_form'(i_cfg_data[1:0]);
                mbqf_pkg::CFG_B0:   r_b0   <= $signed(i_cfg_data);
                mbqf_pkg::CFG_B1:   r_b1   <= $signed(i_cfg_data);
                mbqf_pkg::CFG_B2:   r_b2   <= $signed(i_cfg_data);
                mbqf_pkg::CFG_A1:   r_a1   <= $signed(i_cfg_data);
                mbqf_pkg::CFG_A2:   r_a2   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Delay-state memory
    mbqf_state #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (form_wr),
        .i_rd_en  (accept),
        .i_rd_idx (IDX_W'(s_tuser)),
        .o_rd_row (row_old),
        .i_wr_en  (wr_en),
        .i_wr_idx (IDX_W'(r_chan)),
        .i_wr_row (row_new)
    );

    // Shared multiply-accumulate unit
    mbqf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .o_stat  (mac_stat)
    );

    assign uop = mbqf_pkg::ucode(r_form, r_pc);

    // Operand select
    always_comb begin
        unique case (uop.src)
            mbqf_pkg::SRC_ZERO: opnd = '0;
            mbqf_pkg::SRC_X:    opnd = r_x;
            mbqf_pkg::SRC_W:    opnd = r_w;
            mbqf_pkg::SRC_Y:    opnd = r_y;
            mbqf_pkg::SRC_IN1:  opnd = row_old.in1;
            mbqf_pkg::SRC_IN2:  opnd = row_old.in2;
            mbqf_pkg::SRC_OUT1: opnd = row_old.out1;
            mbqf_pkg::SRC_OUT2: opnd = row_old.out2;
            mbqf_pkg::SRC_INR1: opnd = row_old.inr1;
            mbqf_pkg::SRC_INR2: opnd = row_old.inr2;
            default:            opnd = '0;
        endcase
    end

    // Coefficient select
    always_comb begin
        unique case (uop.coef)
            mbqf_pkg::C_B0: coefv = r_b0;
            mbqf_pkg::C_B1: coefv = r_b1;
            mbqf_pkg::C_B2: coefv = r_b2;
            mbqf_pkg::C_A1: coefv = r_a1;
            mbqf_pkg::C_A2: coefv = r_a2;
            default:        coefv = r_b0;
        endcase
    end

    // New delay state per structure
    always_comb begin
        row_new = row_old;
        unique case (r_form)
            mbqf_pkg::FORM_DF1: begin
                row_new.in2  = row_old.in1;
                row_new.out2 = row_old.out1;
                row_new.in1  = r_x;
                row_new.out1 = r_y;
            end
            mbqf_pkg::FORM_DF2: begin
                row_new.inr2 = row_old.inr1;
                row_new.inr1 = r_w;
            end
            mbqf_pkg::FORM_TDF1: begin
                row_new.in2  = r_t2;
                row_new.inr2 = r_t1;
                row_new.in1  = r_t3;
                row_new.inr1 = r_t4;
            end
            mbqf_pkg::FORM_TDF2: begin
                row_new.in2 = r_t2;
                row_new.in1 = r_t1;
            end
            default: ;
        endcase
    end

    // Output rounding Q9.31 -> Q1.23 with saturation
    always_comb begin
        y_rnd = 41'(r_y) + 41'sd128;
        y_q   = $signed(y_rnd[40:8]);
        if (y_q > 33'sd8388607) begin
            y_sample = 24'h7F_FFFF;
        end else if (y_q < -33'sd8388608) begin
            y_sample = 24'h80_0000;
        end else begin
            y_sample = y_q[23:0];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_half     = r_half;
        n_w        = r_w;
        n_y        = r_y;
        n_t1       = r_t1;
        n_t2       = r_t2;
        n_t3       = r_t3;
        n_t4       = r_t4;
        n_m_tvalid = r_m_tvalid && !m_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        wr_en      = 1'b0;
        mac_ctrl         = '0;
        mac_ctrl.operand = opnd;
        mac_ctrl.coef    = coefv;

        unique case (r_state)
            mbqf_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_pc    = '0;
                    n_half  = 1'b0;
                    n_state = (32'(s_tuser) < CHANNELS) ? mbqf_pkg::S_RUN
                                                        : mbqf_pkg::S_DONE;
                end
            end
            mbqf_pkg::S_RUN: begin
                unique case (uop.kind)
                    mbqf_pkg::U_MUL: begin
                        mac_ctrl.issue = 1'b1;
                        mac_ctrl.hi    = r_half;
                        n_half         = !r_half;
                        if (r_half) begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    mbqf_pkg::U_INIT: begin
                        if (!mac_stat.busy) begin
                            mac_ctrl.init = 1'b1;
                            n_pc          = r_pc + 1'b1;
                        end
                    end
                    mbqf_pkg::U_ADD: begin
                        if (!mac_stat.busy) begin
                            mac_ctrl.add = 1'b1;
                            n_pc         = r_pc + 1'b1;
                        end
                    end
                    mbqf_pkg::U_SAT: begin
                        if (!mac_stat.busy) begin
                            n_pc = r_pc + 1'b1;
                            unique case (uop.dst)
                                mbqf_pkg::DST_W:  n_w  = mac_stat.acc_sat;
                                mbqf_pkg::DST_Y:  n_y  = mac_stat.acc_sat;
                                mbqf_pkg::DST_T1: n_t1 = mac_stat.acc_sat;
                                mbqf_pkg::DST_T2: n_t2 = mac_stat.acc_sat;
                                mbqf_pkg::DST_T3: n_t3 = mac_stat.acc_sat;
                                mbqf_pkg::DST_T4: n_t4 = mac_stat.acc_sat;
                                default: ;
                            endcase
                        end
                    end
                    mbqf_pkg::U_END: begin
                        n_state = mbqf_pkg::S_DONE;
                    end
                    default: begin
                        n_state = mbqf_pkg::S_DONE;
                    end
                endcase
            end
            mbqf_pkg::S_DONE: begin
                // Hand over the result once the output register is free
                if (!r_m_tvalid || m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = r_inrange ? y_sample : '0;
                    n_m_tuser  = r_chan;
                    wr_en      = r_inrange;
                    n_state    = mbqf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mbqf_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mbqf_pkg::S_IDLE;
            r_pc       <= '0;
            r_half     <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pc       <= n_pc;
            r_half     <= n_half;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x       <= {{8{s_tdata[23]}}, s_tdata, 8'd0};
            r_chan    <= s_tuser;
            r_inrange <= (32'(s_tuser) < CHANNELS);
        end
        r_w       <= n_w;
        r_y       <= n_y;
        r_t1      <= n_t1;
        r_t2      <= n_t2;
        r_t3      <= n_t3;
        r_t4      <= n_t4;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

endmodule

>>> rtl/mbqf_mac.sv
// Shared multiply-round-accumulate unit: 21x32 multiplier used twice per product.
// Depends on mbqf_pkg.
module mbqf_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbqf_pkg::t_mac_ctrl i_ctrl,
    output mbqf_pkg::t_mac_stat o_stat
);

    localparam int PROD_W = 53;
    localparam int Q_W    = 42;
    localparam int SUM_W  = 73;

    logic signed [20:0]                   mul_a;
    logic signed [PROD_W-1:0]             prod_w;
    logic signed [PROD_W-1:0]             r_prod;
    logic signed [PROD_W-1:0]             r_part;
    logic                                 r_cvt;
    logic signed [Q_W-1:0]                r_q;
    logic                                 r_qv;
    logic signed [mbqf_pkg::ACC_W-1:0]    r_acc;
    logic signed [SUM_W-1:0]              qsum;

    // Operand half: low 20 bits unsigned, upper 20 bits signed
    assign mul_a  = i_ctrl.hi ? {i_ctrl.operand[39], i_ctrl.operand[39:20]}
                              : {1'b0, i_ctrl.operand[19:0]};
    assign prod_w = mul_a * i_ctrl.coef;

    // Recombine hi*2^20 + lo + half LSB, then floor by 2^30
    assign qsum = (SUM_W'(r_prod) <<< 20) + SUM_W'(r_part);

    // Multiplier and rounding stages
    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue) begin
            r_prod <= prod_w;
        end
        if (i_ctrl.issue && i_ctrl.hi) begin
            r_part <= r_prod + 53'sd536870912;
        end
        if (r_cvt) begin
            r_q <= $signed(qsum[71:30]);
        end
    end

    // Pipeline flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvt <= 1'b0;
            r_qv  <= 1'b0;
        end else begin
            r_cvt <= i_ctrl.issue && i_ctrl.hi;
            r_qv  <= r_cvt;
        end
    end

    // Accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_acc <= mbqf_pkg::ACC_W'(i_ctrl.operand);
        end else if (i_ctrl.add) begin
            r_acc <= r_acc + mbqf_pkg::ACC_W'(i_ctrl.operand);
        end else if (r_qv) begin
            r_acc <= r_acc + mbqf_pkg::ACC_W'(r_q);
        end
    end

    assign o_stat.busy    = r_cvt | r_qv;
    assign o_stat.acc_sat = mbqf_pkg::sat40(r_acc);

endmodule

>>> rtl/mbqf_state.sv
// Per-channel delay-state memory with one valid bit per row (invalid rows read as zero).
// Depends on mbqf_pkg.
module mbqf_state #(
    parameter int CHANNELS = 8,
    parameter int IDX_W    = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output mbqf_pkg::t_row   o_rd_row,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  mbqf_pkg::t_row   i_wr_row
);

    mbqf_pkg::t_row       r_mem [CHANNELS];
    logic [CHANNELS-1:0]  r_vld;
    mbqf_pkg::t_row       r_rd_row;
    logic                 r_rd_vld;

    // Row storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_idx];
        end
    end

    // Valid bits: cleared by reset and by any write to the structure register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clear) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    assign o_rd_row = r_rd_vld ? r_rd_row : '0;

endmodule
